// ===== sv/triangle_edge_adjacency_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the triangle edge adjacency block
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_ADJACENCY_DEFINES_SVH
`define TRIANGLE_EDGE_ADJACENCY_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TAE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("triangle_edge_adjacency: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define TAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("triangle_edge_adjacency: next-cycle check failed");

`endif

// ===== sv/tae_pkg.sv =====
// ----------------------------------------------------------------------------
// tae_pkg
// Shared types and constants of the triangle edge adjacency block.
// ----------------------------------------------------------------------------
package tae_pkg;

    localparam int VERTEX_W  = 16;
    localparam int INDEX_W   = 10;
    localparam int NBR_W     = 11;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COMPUTE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

// ===== sv/tae_edge_cmp.sv =====
// ----------------------------------------------------------------------------
// tae_edge_cmp
// Shared edge comparator: orders both vertex pairs and tests them for equality.
// ----------------------------------------------------------------------------
module tae_edge_cmp #(
    parameter int W = 16
) (
    input  logic [W-1:0] a_first,
    input  logic [W-1:0] a_second,
    input  logic [W-1:0] b_first,
    input  logic [W-1:0] b_second,
    output logic         match
);

    logic [W-1:0] a_lo, a_hi, b_lo, b_hi;

    always_comb begin
        a_lo  = (a_first < a_second) ? a_first  : a_second;
        a_hi  = (a_first < a_second) ? a_second : a_first;
        b_lo  = (b_first < b_second) ? b_first  : b_second;
        b_hi  = (b_first < b_second) ? b_second : b_first;
        match = (a_lo == b_lo) && (a_hi == b_hi);
    end

endmodule

// ===== sv/triangle_edge_adjacency.sv =====
// ----------------------------------------------------------------------------
// triangle_edge_adjacency
// Triangle table with an edge adjacency pass run by one shared edge comparator.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+------------------------------------
//   s_      | in  | s_tvalid/s_tready  | action, three vertices, read index
//   m_      | out | m_tvalid/m_tready  | three neighbor slots, count, status
//
// Load, clear and an out-of-range read are answered from the idle state; an
// in-range read first waits on the neighbor memory. Compute runs a zeroing
// sweep over the loaded rows, ending there below two triangles, then nine
// comparator steps per pair plus the row fetch and write-back around them.
// Reset is synchronous; the neighbor memory needs no clearing pass after it.
// A new word is taken only when idle and the result register is free or
// being emptied in the same cycle.
// ----------------------------------------------------------------------------
`include "triangle_edge_adjacency_defines.svh"

module triangle_edge_adjacency #(
    parameter int MAX_TRIANGLES     = 1024,
    parameter int VERTEX_INDEX_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action[1:0], vertex_first[17:2], vertex_second[33:18],
    // vertex_third[49:34], triangle_index[59:50], zero fill above
    input  logic [tae_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // neighbor_first[10:0], neighbor_second[21:11], neighbor_third[32:22],
    // triangle_count[43:33], status[45:44], zero fill above
    output logic [tae_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW = $clog2(MAX_TRIANGLES + 1);
    localparam int VB = (VERTEX_INDEX_BITS < tae_pkg::VERTEX_W) ?
                        VERTEX_INDEX_BITS : tae_pkg::VERTEX_W;
    localparam int RW = (CW > tae_pkg::INDEX_W) ? CW : tae_pkg::INDEX_W;
    localparam int OW = tae_pkg::NBR_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDW,
        ST_CLR,
        ST_IRD,
        ST_ICAP,
        ST_JCAP,
        ST_CMP,
        ST_JWR,
        ST_IWR
    } state_t;

    typedef logic [2:0][VB-1:0] tri_row_t;
    typedef logic [2:0][CW-1:0] nbr_row_t;

    // input word fields
    tae_pkg::action_t                s_action;
    logic [tae_pkg::VERTEX_W-1:0]    s_vertex_first;
    logic [tae_pkg::VERTEX_W-1:0]    s_vertex_second;
    logic [tae_pkg::VERTEX_W-1:0]    s_vertex_third;
    logic [tae_pkg::INDEX_W-1:0]     s_triangle_index;
    logic [RW-1:0]                   idx_ext;

    assign s_action         = tae_pkg::action_t'(s_tdata[1:0]);
    assign s_vertex_first   = s_tdata[17:2];
    assign s_vertex_second  = s_tdata[33:18];
    assign s_vertex_third   = s_tdata[49:34];
    assign s_triangle_index = s_tdata[59:50];
    assign idx_ext          = RW'(s_triangle_index);

    // sequencer registers
    state_t                            state_reg, state_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic [IW-1:0]                     i_reg, i_next;
    logic [IW-1:0]                     j_reg, j_next;
    logic [IW-1:0]                     addr_reg, addr_next;
    logic [1:0]                        ki_reg, ki_next;
    logic [1:0]                        kj_reg, kj_next;
    logic                              live_reg, live_next;
    tri_row_t                          tri_i_reg, tri_i_next;
    tri_row_t                          tri_j_reg, tri_j_next;
    nbr_row_t                          nbr_i_reg, nbr_i_next;
    nbr_row_t                          nbr_j_reg, nbr_j_next;
    logic                              m_valid_reg, m_valid_next;
    logic [2:0][OW-1:0]                out_nbr_reg, out_nbr_next;
    logic [OW-1:0]                     out_count_reg, out_count_next;
    logic [tae_pkg::STATUS_W-1:0]      out_status_reg, out_status_next;

    // memory ports
    tri_row_t                          tri_mem [MAX_TRIANGLES];
    nbr_row_t                          nbr_mem [MAX_TRIANGLES];
    logic                              tri_we, nbr_we;
    logic [IW-1:0]                     tri_waddr, nbr_waddr;
    logic [IW-1:0]                     tri_raddr, nbr_raddr;
    tri_row_t                          tri_wdata, tri_rd_reg;
    nbr_row_t                          nbr_wdata, nbr_rd_reg;

    // comparator operands
    logic [1:0]                        ki_nx, kj_nx;
    logic                              edge_match;
    logic                              edge_live;
    logic [CW-1:0]                     i_plus1, j_plus1;
    logic                              accept;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign ki_nx    = (ki_reg == 2'd2) ? 2'd0 : ki_reg + 2'd1;
    assign kj_nx    = (kj_reg == 2'd2) ? 2'd0 : kj_reg + 2'd1;
    assign i_plus1  = CW'(i_reg) + CW'(1);
    assign j_plus1  = CW'(j_reg) + CW'(1);
    assign edge_live = (kj_reg == 2'd0) ? (nbr_i_reg[ki_reg] == '0) : live_reg;

    tae_edge_cmp #(
        .W (VB)
    ) u_edge_cmp (
        .a_first  (tri_i_reg[ki_reg]),
        .a_second (tri_i_reg[ki_nx]),
        .b_first  (tri_j_reg[kj_reg]),
        .b_second (tri_j_reg[kj_nx]),
        .match    (edge_match)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        addr_next       = addr_reg;
        ki_next         = ki_reg;
        kj_next         = kj_reg;
        live_next       = live_reg;
        tri_i_next      = tri_i_reg;
        tri_j_next      = tri_j_reg;
        nbr_i_next      = nbr_i_reg;
        nbr_j_next      = nbr_j_reg;
        m_valid_next    = m_valid_reg;
        out_nbr_next    = out_nbr_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        tri_we          = 1'b0;
        nbr_we          = 1'b0;
        tri_waddr       = count_reg[IW-1:0];
        nbr_waddr       = i_reg;
        tri_raddr       = i_reg;
        nbr_raddr       = i_reg;
        tri_wdata       = '0;
        nbr_wdata       = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_action)
                        tae_pkg::ACT_LOAD: begin
                            m_valid_next = 1'b1;
                            out_nbr_next = '0;
                            if (count_reg < CW'(MAX_TRIANGLES)) begin
                                tri_we       = 1'b1;
                                tri_waddr    = count_reg[IW-1:0];
                                tri_wdata[0] = s_vertex_first[VB-1:0];
                                tri_wdata[1] = s_vertex_second[VB-1:0];
                                tri_wdata[2] = s_vertex_third[VB-1:0];
                                nbr_we       = 1'b1;
                                nbr_waddr    = count_reg[IW-1:0];
                                count_next   = count_reg + CW'(1);
                                out_status_next = tae_pkg::STATUS_OK;
                            end else begin
                                out_status_next = tae_pkg::STATUS_FULL;
                            end
                            out_count_next = OW'(count_next);
                        end
                        tae_pkg::ACT_COMPUTE: begin
                            addr_next  = '0;
                            state_next = ST_CLR;
                        end
                        tae_pkg::ACT_READ: begin
                            if (idx_ext < RW'(count_reg)) begin
                                nbr_raddr  = idx_ext[IW-1:0];
                                state_next = ST_RDW;
                            end else begin
                                m_valid_next    = 1'b1;
                                out_nbr_next    = '0;
                                out_count_next  = OW'(count_reg);
                                out_status_next = tae_pkg::STATUS_RANGE;
                            end
                        end
                        tae_pkg::ACT_CLEAR: begin
                            count_next      = '0;
                            m_valid_next    = 1'b1;
                            out_nbr_next    = '0;
                            out_count_next  = '0;
                            out_status_next = tae_pkg::STATUS_OK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDW: begin
                m_valid_next    = 1'b1;
                out_nbr_next[0] = OW'(nbr_rd_reg[0]);
                out_nbr_next[1] = OW'(nbr_rd_reg[1]);
                out_nbr_next[2] = OW'(nbr_rd_reg[2]);
                out_count_next  = OW'(count_reg);
                out_status_next = tae_pkg::STATUS_OK;
                state_next      = ST_IDLE;
            end
            ST_CLR: begin
                // zero the loaded rows; rows above the count are zeroed on load
                if (count_reg != '0) begin
                    nbr_we    = 1'b1;
                    nbr_waddr = addr_reg;
                end
                if ((count_reg == '0) || (CW'(addr_reg) + CW'(1) >= count_reg)) begin
                    if (count_reg < CW'(2)) begin
                        m_valid_next    = 1'b1;
                        out_nbr_next    = '0;
                        out_count_next  = OW'(count_reg);
                        out_status_next = tae_pkg::STATUS_OK;
                        state_next      = ST_IDLE;
                    end else begin
                        i_next     = '0;
                        state_next = ST_IRD;
                    end
                end else begin
                    addr_next = addr_reg + IW'(1);
                end
            end
            ST_IRD: begin
                tri_raddr  = i_reg;
                nbr_raddr  = i_reg;
                j_next     = i_reg + IW'(1);
                state_next = ST_ICAP;
            end
            ST_ICAP: begin
                tri_i_next = tri_rd_reg;
                nbr_i_next = nbr_rd_reg;
                tri_raddr  = j_reg;
                nbr_raddr  = j_reg;
                state_next = ST_JCAP;
            end
            ST_JCAP: begin
                tri_j_next = tri_rd_reg;
                nbr_j_next = nbr_rd_reg;
                ki_next    = 2'd0;
                kj_next    = 2'd0;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // an edge of i is tested only if its slot was empty on entry
                live_next = edge_live;
                if (edge_live && edge_match) begin
                    nbr_i_next[ki_reg] = j_plus1;
                    nbr_j_next[kj_reg] = i_plus1;
                end
                kj_next = kj_nx;
                if (kj_reg == 2'd2) begin
                    ki_next = ki_nx;
                    if (ki_reg == 2'd2) begin
                        state_next = ST_JWR;
                    end
                end
            end
            ST_JWR: begin
                nbr_we    = 1'b1;
                nbr_waddr = j_reg;
                nbr_wdata = nbr_j_reg;
                if (j_plus1 < count_reg) begin
                    j_next     = j_reg + IW'(1);
                    tri_raddr  = j_reg + IW'(1);
                    nbr_raddr  = j_reg + IW'(1);
                    state_next = ST_JCAP;
                end else begin
                    state_next = ST_IWR;
                end
            end
            ST_IWR: begin
                nbr_we    = 1'b1;
                nbr_waddr = i_reg;
                nbr_wdata = nbr_i_reg;
                if (CW'(i_reg) + CW'(2) < count_reg) begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_IRD;
                end else begin
                    m_valid_next    = 1'b1;
                    out_nbr_next    = '0;
                    out_count_next  = OW'(count_reg);
                    out_status_next = tae_pkg::STATUS_OK;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg          <= i_next;
        j_reg          <= j_next;
        addr_reg       <= addr_next;
        ki_reg         <= ki_next;
        kj_reg         <= kj_next;
        live_reg       <= live_next;
        tri_i_reg      <= tri_i_next;
        tri_j_reg      <= tri_j_next;
        nbr_i_reg      <= nbr_i_next;
        nbr_j_reg      <= nbr_j_next;
        out_nbr_reg    <= out_nbr_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (tri_we) begin
            tri_mem[tri_waddr] <= tri_wdata;
        end
        tri_rd_reg <= tri_mem[tri_raddr];
    end

    always_ff @(posedge aclk) begin
        if (nbr_we) begin
            nbr_mem[nbr_waddr] <= nbr_wdata;
        end
        nbr_rd_reg <= nbr_mem[nbr_raddr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_count_reg,
                       out_nbr_reg[2], out_nbr_reg[1], out_nbr_reg[0]};

    `TAE_ASSERT_NEXT(a_load_counts, aclk, aresetn,
        accept && (s_action == tae_pkg::ACT_LOAD) && (count_reg < CW'(MAX_TRIANGLES)),
        count_reg == $past(count_reg) + CW'(1))
    `TAE_ASSERT_NOW(a_walk_order, aclk, aresetn,
        state_reg == ST_CMP, (j_reg > i_reg) && (j_plus1 <= count_reg))
    `TAE_ASSERT_NOW(a_range_empty, aclk, aresetn,
        m_valid_reg && (out_status_reg == tae_pkg::STATUS_RANGE), out_nbr_reg == '0)

endmodule
